/* rtl/phm_pkg.sv */
// Shared types and constants of the ping health monitor.
// Depends on nothing; imported by the controller, the datapath and the top level.
package phm_pkg;

  // Number of monitored clients that the table holds.
  localparam int unsigned ENTRIES = 16;
  // Field widths fixed by the item format.
  localparam int unsigned ENT_W   = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LIM_W   = 5;
  // The entry field reaches 16 entries at most, so storage stops there.
  localparam int unsigned DEPTH   = (ENTRIES < 16) ? ENTRIES : 16;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RETURN  = 2'd1,
    OP_SET_EN  = 2'd2,
    OP_SET_THR = 2'd3
  } phm_op_e;

  typedef enum logic [2:0] {
    KIND_PING      = 3'd0,
    KIND_LATE_WARN = 3'd1,
    KIND_LATE_FTL  = 3'd2,
    KIND_WRONG_KEY = 3'd3,
    KIND_STROKE    = 3'd4,
    KIND_CMD_OK    = 3'd5,
    KIND_BAD_ENTRY = 3'd6,
    KIND_BAD_THR   = 3'd7
  } phm_kind_e;

  typedef enum logic [1:0] {
    CFG_HEALTH_EN = 2'd0,
    CFG_ACTIVE    = 2'd1,
    CFG_WD_CODE   = 2'd2,
    CFG_UNUSED    = 2'd3
  } phm_cfg_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // latch the input beat
    logic scan;    // visit one table entry
    logic stroke;  // emit the watchdog stroke
    logic exec;    // run a return or a command
  } phm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic tick;       // input beat is a tick
    logic scan_go;    // tick has entries to scan
    logic scan_last;  // current scan entry is the final one
    logic out_free;   // output register can take a result this cycle
  } phm_stat_t;

endpackage

/* rtl/phm_ctrl.sv */
// Sequencer of the ping health monitor: steps a tick through its scan and stroke,
// or a return or command through its execute state. Depends on phm_pkg.
module phm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  phm_pkg::phm_stat_t stat_i,
  output phm_pkg::phm_cmd_t  cmd_o
);
  import phm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STROKE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!stat_i.tick) begin
            state_d = ST_EXEC;
          end else if (stat_i.scan_go) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_STROKE;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.out_free) begin
          cmd_o.scan = 1'b1;
          if (stat_i.scan_last) begin
            state_d = ST_STROKE;
          end
        end
      end
      ST_STROKE: begin
        if (stat_i.out_free) begin
          cmd_o.stroke = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/phm_dp.sv */
// Datapath of the ping health monitor: configuration registers, entry table,
// key and warning counters, scan index and the output register. Depends on phm_pkg.
module phm_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         entry_i,
  input  logic [31:0]        key_i,
  input  logic               enable_i,
  input  logic [31:0]        warn_cycles_i,
  input  logic [31:0]        fatal_cycles_i,
  input  phm_pkg::phm_cmd_t  cmd_i,
  output phm_pkg::phm_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic [3:0]         entry_res_o,
  output logic [31:0]        key_res_o,
  output logic [31:0]        warning_total_o,
  output logic [31:0]        stroke_code_o,
  output logic               last_o
);
  import phm_pkg::*;

  // Configuration
  logic              health_en_q;
  logic [LIM_W-1:0]  active_q;
  logic [WORD_W-1:0] wd_code_q;

  // Latched input beat
  logic [1:0]        op_q;
  logic [ENT_W-1:0]  ent_q;
  logic [WORD_W-1:0] rkey_q;
  logic              en_q;
  logic [WORD_W-1:0] wc_q;
  logic [WORD_W-1:0] fc_q;

  // Scan control
  logic [LIM_W-1:0]  lim_q;
  logic [LIM_W-1:0]  lim_in;
  logic [IDX_W-1:0]  idx_q;

  // Entry table and counters
  logic [WORD_W-1:0] wait_q  [DEPTH];
  logic [WORD_W-1:0] ekey_q  [DEPTH];
  logic              on_q    [DEPTH];
  logic [WORD_W-1:0] warn_q  [DEPTH];
  logic [WORD_W-1:0] fatal_q [DEPTH];
  logic [WORD_W-1:0] next_key_q;
  logic [WORD_W-1:0] late_q;
  logic [WORD_W-1:0] late_inc;

  // Output register
  logic              ovalid_q;
  logic [2:0]        okind_q;
  logic [ENT_W-1:0]  oent_q;
  logic [WORD_W-1:0] okey_q;
  logic [WORD_W-1:0] owt_q;
  logic [WORD_W-1:0] ocode_q;
  logic              olast_q;

  // Step results
  logic              out_free;
  logic [IDX_W-1:0]  ra;
  logic [WORD_W-1:0] rd_wait;
  logic [WORD_W-1:0] rd_key;
  logic              rd_on;
  logic [WORD_W-1:0] rd_warn;
  logic [WORD_W-1:0] rd_fatal;
  logic              bad_ent;
  logic              emit;
  phm_kind_e         r_kind;
  logic [ENT_W-1:0]  r_ent;
  logic [WORD_W-1:0] r_key;
  logic [WORD_W-1:0] r_wt;
  logic [WORD_W-1:0] r_code;
  logic              r_last;
  logic              wr_wait;
  logic [WORD_W-1:0] wait_new;
  logic              wr_key;
  logic [WORD_W-1:0] key_new;
  logic              wr_on;
  logic              wr_thr;
  logic              bump_key;
  logic              bump_late;

  assign out_free = !ovalid_q || !out_stall_i;
  assign lim_in   = (active_q > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : active_q;
  assign bad_ent  = (WORD_W'(ent_q) >= WORD_W'(ENTRIES));
  assign late_inc = late_q + 1'b1;

  assign stat_o.tick      = (opcode_i == OP_TICK);
  assign stat_o.scan_go   = health_en_q && (lim_in != '0);
  assign stat_o.scan_last = ((LIM_W'(idx_q) + 1'b1) == lim_q);
  assign stat_o.out_free  = out_free;

  // One table row is read per cycle: the scan row or the addressed row.
  assign ra       = cmd_i.scan ? idx_q : ent_q[IDX_W-1:0];
  assign rd_wait  = wait_q[ra];
  assign rd_key   = ekey_q[ra];
  assign rd_on    = on_q[ra];
  assign rd_warn  = warn_q[ra];
  assign rd_fatal = fatal_q[ra];

  always_comb begin
    emit      = 1'b0;
    r_kind    = KIND_PING;
    r_ent     = '0;
    r_key     = '0;
    r_wt      = '0;
    r_code    = '0;
    r_last    = 1'b0;
    wr_wait   = 1'b0;
    wait_new  = rd_wait + 1'b1;
    wr_key    = 1'b0;
    key_new   = next_key_q;
    wr_on     = 1'b0;
    wr_thr    = 1'b0;
    bump_key  = 1'b0;
    bump_late = 1'b0;

    if (cmd_i.scan && rd_on) begin
      r_ent   = ENT_W'(idx_q);
      wr_wait = 1'b1;
      if (rd_wait == '0) begin
        emit     = 1'b1;
        r_kind   = KIND_PING;
        r_key    = next_key_q;
        wr_key   = 1'b1;
        bump_key = 1'b1;
      end else if (rd_wait == rd_warn) begin
        emit      = 1'b1;
        r_kind    = KIND_LATE_WARN;
        r_wt      = late_inc;
        bump_late = 1'b1;
      end else if (rd_wait == rd_fatal) begin
        emit   = 1'b1;
        r_kind = KIND_LATE_FTL;
      end
    end

    if (cmd_i.stroke) begin
      emit   = 1'b1;
      r_kind = KIND_STROKE;
      r_code = wd_code_q;
      r_last = 1'b1;
    end

    if (cmd_i.exec) begin
      r_ent  = ent_q;
      r_last = 1'b1;
      if (bad_ent) begin
        emit   = 1'b1;
        r_kind = KIND_BAD_ENTRY;
      end else begin
        unique case (op_q)
          OP_RETURN: begin
            if (rkey_q != rd_key) begin
              emit   = 1'b1;
              r_kind = KIND_WRONG_KEY;
              r_key  = rkey_q;
            end else begin
              // matching return: clear quietly
              wr_wait  = 1'b1;
              wait_new = '0;
              wr_key   = 1'b1;
              key_new  = '0;
            end
          end
          OP_SET_EN: begin
            emit   = 1'b1;
            r_kind = KIND_CMD_OK;
            wr_on  = 1'b1;
          end
          OP_SET_THR: begin
            emit = 1'b1;
            if (wc_q > fc_q) begin
              r_kind = KIND_BAD_THR;
            end else begin
              r_kind = KIND_CMD_OK;
              wr_thr = 1'b1;
            end
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      health_en_q <= 1'b1;
      active_q    <= '0;
      wd_code_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEALTH_EN: health_en_q <= cfg_data_i[0];
        CFG_ACTIVE:    active_q    <= cfg_data_i[LIM_W-1:0];
        CFG_WD_CODE:   wd_code_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Input beat and scan bound
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      ent_q  <= entry_i;
      rkey_q <= key_i;
      en_q   <= enable_i;
      wc_q   <= warn_cycles_i;
      fc_q   <= fatal_cycles_i;
      lim_q  <= lim_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Entry table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        wait_q[i]  <= '0;
        ekey_q[i]  <= '0;
        on_q[i]    <= 1'b1;
        warn_q[i]  <= '0;
        fatal_q[i] <= '0;
      end
    end else begin
      if (wr_wait) begin
        wait_q[ra] <= wait_new;
      end
      if (wr_key) begin
        ekey_q[ra] <= key_new;
      end
      if (wr_on) begin
        on_q[ra] <= en_q;
      end
      if (wr_thr) begin
        warn_q[ra]  <= wc_q;
        fatal_q[ra] <= fc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_key_q <= '0;
      late_q     <= '0;
    end else begin
      if (bump_key) begin
        next_key_q <= next_key_q + 1'b1;
      end
      if (bump_late) begin
        late_q <= late_inc;
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_free) begin
      ovalid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      okind_q <= r_kind;
      oent_q  <= r_ent;
      okey_q  <= r_key;
      owt_q   <= r_wt;
      ocode_q <= r_code;
      olast_q <= r_last;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign kind_o          = okind_q;
  assign entry_res_o     = oent_q;
  assign key_res_o       = okey_q;
  assign warning_total_o = owt_q;
  assign stroke_code_o   = ocode_q;
  assign last_o          = olast_q;

endmodule

/* rtl/ping_health_monitor.sv */
// Top level of the ping health monitor: controller plus datapath.
// Depends on phm_pkg, phm_ctrl and phm_dp.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   opcode, entry, key, enable, thresholds
//   result    out        out_valid_o / out_stall_i kind, entry_res, key_res, totals, last
//   config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// A tick is accepted, then scans each entry below the scan bound (zero while health
// checking is off) and ends with the stroke.
// A return or command is accepted, then run in the execute state.
// Each table step holds while the output register is full and stalled.
// Reset clears the table in place; no clearing pass follows it.
module ping_health_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  entry_i,
  input  logic [31:0] key_i,
  input  logic        enable_i,
  input  logic [31:0] warn_cycles_i,
  input  logic [31:0] fatal_cycles_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  entry_res_o,
  output logic [31:0] key_res_o,
  output logic [31:0] warning_total_o,
  output logic [31:0] stroke_code_o,
  output logic        last_o
);
  import phm_pkg::*;

  phm_cmd_t  cmd;
  phm_stat_t stat;

  phm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  phm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .entry_i         (entry_i),
    .key_i           (key_i),
    .enable_i        (enable_i),
    .warn_cycles_i   (warn_cycles_i),
    .fatal_cycles_i  (fatal_cycles_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .entry_res_o     (entry_res_o),
    .key_res_o       (key_res_o),
    .warning_total_o (warning_total_o),
    .stroke_code_o   (stroke_code_o),
    .last_o          (last_o)
  );

  // A stroke always closes its tick.
  a_stroke_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_STROKE) |-> last_o)
    else $error("stroke beat without last");

  // Scan results never close an item.
  a_scan_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == KIND_PING) || (kind_o == KIND_LATE_WARN) ||
                    (kind_o == KIND_LATE_FTL)) |-> !last_o)
    else $error("scan beat marked last");

  // Only one item at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // Stroke code is zero on every other kind.
  a_code_only_stroke: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_STROKE) |-> (stroke_code_o == '0))
    else $error("stroke code on a non-stroke beat");

endmodule

/* verif/tb.sv */
// Self-checking testbench for ping_health_monitor: a directed table of requests, then random phases.
// Depends on phm_pkg and the RTL; an in-bench model or a hand-written row gives each report, checked in arrival order.
module tb;
  import phm_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;
  localparam int unsigned EXEC_CYCLES   = 4;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned SLOTS         = 16;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_REQS    = 40;

  typedef struct packed {
    phm_op_e     op;
    logic [3:0]  ent;
    logic [31:0] key;
    logic        en;
    logic [31:0] warn;
    logic [31:0] fatal;
  } request_t;

  typedef struct packed {
    phm_kind_e   kind;
    logic [3:0]  ent;
    logic [31:0] key;
    logic [31:0] warn_total;
    logic [31:0] code;
    logic        last;
  } report_t;

  typedef struct {
    bit          is_reg;
    phm_cfg_e    reg_idx;
    logic [31:0] reg_val;
    request_t    rq;
    bit          typed;
    report_t     want;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [3:0]  entry_i;
  logic [31:0] key_i;
  logic        enable_i;
  logic [31:0] warn_cycles_i;
  logic [31:0] fatal_cycles_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [3:0]  entry_res_o;
  logic [31:0] key_res_o;
  logic [31:0] warning_total_o;
  logic [31:0] stroke_code_o;
  logic        last_o;

  ping_health_monitor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .entry_i         (entry_i),
    .key_i           (key_i),
    .enable_i        (enable_i),
    .warn_cycles_i   (warn_cycles_i),
    .fatal_cycles_i  (fatal_cycles_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .entry_res_o     (entry_res_o),
    .key_res_o       (key_res_o),
    .warning_total_o (warning_total_o),
    .stroke_code_o   (stroke_code_o),
    .last_o          (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow of the monitor: table, key counter, warning total and registers.
  logic [31:0] m_count [SLOTS];
  logic [31:0] m_key   [SLOTS];
  logic        m_on    [SLOTS];
  logic [31:0] m_warn  [SLOTS];
  logic [31:0] m_fatal [SLOTS];
  logic [31:0] m_next_key;
  logic [31:0] m_late_total;
  logic        m_health_en;
  logic [4:0]  m_active;
  logic [31:0] m_wd_code;

  report_t    step_reports [$];
  report_t    due_reports  [$];
  table_row_t dir_rows     [$];

  int  err_cnt     = 0;
  int  request_cnt = 0;
  int  report_cnt  = 0;
  int  setting_cnt = 0;
  int  kind_seen [8];
  bit  quiet = 1'b0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic report_t mk_report(phm_kind_e kind, logic [3:0] ent, logic [31:0] key,
                                        logic [31:0] wt, logic [31:0] code, logic last);
    report_t r;
    r.kind       = kind;
    r.ent        = ent;
    r.key        = key;
    r.warn_total = wt;
    r.code       = code;
    r.last       = last;
    return r;
  endfunction

  // Advance the shadow by one request and leave its reports in step_reports.
  function automatic void predict_reports(request_t rq);
    int unsigned bound;
    step_reports.delete();
    if (rq.op == OP_TICK) begin
      if (m_health_en) begin
        bound = m_active;
        if (bound > ENTRIES) bound = ENTRIES;
        if (bound > SLOTS) bound = SLOTS;
        for (int unsigned i = 0; i < bound; i++) begin
          if (!m_on[i]) continue;
          if (m_count[i] == 32'd0) begin
            m_key[i] = m_next_key;
            step_reports.push_back(mk_report(KIND_PING, 4'(i), m_next_key, '0, '0, 1'b0));
            m_next_key = m_next_key + 32'd1;
            m_count[i] = 32'd1;
          end else begin
            if (m_count[i] == m_warn[i]) begin
              m_late_total = m_late_total + 32'd1;
              step_reports.push_back(mk_report(KIND_LATE_WARN, 4'(i), '0, m_late_total, '0,
                                               1'b0));
            end else if (m_count[i] == m_fatal[i]) begin
              step_reports.push_back(mk_report(KIND_LATE_FTL, 4'(i), '0, '0, '0, 1'b0));
            end
            m_count[i] = m_count[i] + 32'd1;
          end
        end
      end
      step_reports.push_back(mk_report(KIND_STROKE, '0, '0, '0, m_wd_code, 1'b0));
    end else if (int'(rq.ent) >= int'(ENTRIES)) begin
      step_reports.push_back(mk_report(KIND_BAD_ENTRY, rq.ent, '0, '0, '0, 1'b0));
    end else if (rq.op == OP_RETURN) begin
      if (rq.key != m_key[rq.ent]) begin
        step_reports.push_back(mk_report(KIND_WRONG_KEY, rq.ent, rq.key, '0, '0, 1'b0));
      end else begin
        m_count[rq.ent] = '0;
        m_key[rq.ent]   = '0;
      end
    end else if (rq.op == OP_SET_EN) begin
      m_on[rq.ent] = rq.en;
      step_reports.push_back(mk_report(KIND_CMD_OK, rq.ent, '0, '0, '0, 1'b0));
    end else if (rq.warn > rq.fatal) begin
      step_reports.push_back(mk_report(KIND_BAD_THR, rq.ent, '0, '0, '0, 1'b0));
    end else begin
      m_warn[rq.ent]  = rq.warn;
      m_fatal[rq.ent] = rq.fatal;
      step_reports.push_back(mk_report(KIND_CMD_OK, rq.ent, '0, '0, '0, 1'b0));
    end
    if (step_reports.size() > 0) step_reports[step_reports.size() - 1].last = 1'b1;
  endfunction

  // Mostly well-formed traffic: returns usually carry the live key, thresholds are mostly small.
  function automatic request_t random_request();
    request_t    rq;
    int unsigned r;
    int unsigned s;
    rq.ent   = 4'($urandom_range(0, SLOTS - 1));
    rq.key   = $urandom();
    rq.en    = 1'($urandom_range(0, 1));
    rq.warn  = $urandom();
    rq.fatal = $urandom();
    r = $urandom_range(0, 99);
    if (r < 35) begin
      rq.op = OP_TICK;
    end else if (r < 70) begin
      rq.op = OP_RETURN;
      if ($urandom_range(0, 4) != 0) rq.key = m_key[rq.ent];
    end else if (r < 80) begin
      rq.op = OP_SET_EN;
      rq.en = ($urandom_range(0, 3) != 0);
    end else begin
      rq.op = OP_SET_THR;
      s = $urandom_range(0, 9);
      if (s == 1) begin
        rq.warn  = $urandom_range(1, 6);
        rq.fatal = 32'hFFFF_FFFF;
      end else if (s == 2) begin
        rq.fatal = $urandom_range(0, 5);
        rq.warn  = rq.fatal + $urandom_range(1, 3);
      end else if (s > 2) begin
        rq.warn  = $urandom_range(1, 5);
        rq.fatal = rq.warn + $urandom_range(0, 5);
      end
    end
    return rq;
  endfunction

  function automatic void add_req(phm_op_e op, logic [3:0] ent, logic [31:0] key, logic en,
                                  logic [31:0] warn, logic [31:0] fatal);
    table_row_t row;
    row = '{is_reg: 1'b0, reg_idx: CFG_HEALTH_EN, reg_val: '0, rq: '0, typed: 1'b0,
            want: '0};
    row.rq.op    = op;
    row.rq.ent   = ent;
    row.rq.key   = key;
    row.rq.en    = en;
    row.rq.warn  = warn;
    row.rq.fatal = fatal;
    dir_rows.push_back(row);
  endfunction

  // Attach a hand-written expectation to the row just added.
  function automatic void add_chk(report_t want);
    dir_rows[dir_rows.size() - 1].typed = 1'b1;
    dir_rows[dir_rows.size() - 1].want  = want;
  endfunction

  function automatic void add_reg(phm_cfg_e idx, logic [31:0] val);
    table_row_t row;
    row = '{is_reg: 1'b0, reg_idx: CFG_HEALTH_EN, reg_val: '0, rq: '0, typed: 1'b0,
            want: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    dir_rows.push_back(row);
  endfunction

  task automatic issue(request_t rq, bit typed, report_t want);
    int unsigned gap;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= rq.op;
    entry_i        <= rq.ent;
    key_i          <= rq.key;
    enable_i       <= rq.en;
    warn_cycles_i  <= rq.warn;
    fatal_cycles_i <= rq.fatal;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    request_cnt++;
    predict_reports(rq);
    if (typed) begin
      due_reports.push_back(want);
    end else begin
      foreach (step_reports[i]) due_reports.push_back(step_reports[i]);
    end
  endtask

  // Drop valid and hold until every report is in; a matching return may still be executing.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (EXEC_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(phm_cfg_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    setting_cnt++;
    case (idx)
      CFG_HEALTH_EN: m_health_en = val[0];
      CFG_ACTIVE:    m_active    = val[4:0];
      CFG_WD_CODE:   m_wd_code   = val;
      default: ;
    endcase
  endtask

  // Receiver stall pattern: runs of random length, none in quiet phases.
  always @(posedge clk_i) begin : stall_gen
    int unsigned run;
    int unsigned g;
    if (run != 0) begin
      run = run - 1;
    end else begin
      g = quiet ? 0 : idle_len();
      out_stall_i <= (g != 0);
      run = g;
    end
  end

  always @(posedge clk_i) begin : report_check
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      report_cnt++;
      kind_seen[kind_o]++;
      if (due_reports.size() == 0) begin
        $error("unexpected report: kind %0d entry %0d", kind_o, entry_res_o);
        err_cnt++;
      end else begin
        want = due_reports.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          err_cnt++;
        end
        if (entry_res_o !== want.ent) begin
          $error("entry_res: expected %0d, got %0d", want.ent, entry_res_o);
          err_cnt++;
        end
        if (key_res_o !== want.key) begin
          $error("key_res: expected %h, got %h", want.key, key_res_o);
          err_cnt++;
        end
        if (warning_total_o !== want.warn_total) begin
          $error("warning_total: expected %0d, got %0d", want.warn_total, warning_total_o);
          err_cnt++;
        end
        if (stroke_code_o !== want.code) begin
          $error("stroke_code: expected %h, got %h", want.code, stroke_code_o);
          err_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [31:0] act;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_HEALTH_EN;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_TICK;
    entry_i        = '0;
    key_i          = '0;
    enable_i       = 1'b0;
    warn_cycles_i  = '0;
    fatal_cycles_i = '0;
    out_stall_i    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      m_count[i] = '0;
      m_key[i]   = '0;
      m_on[i]    = 1'b1;
      m_warn[i]  = '0;
      m_fatal[i] = '0;
    end
    m_next_key   = '0;
    m_late_total = '0;
    m_health_en  = 1'b1;
    m_active     = '0;
    m_wd_code    = '0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: nothing scanned, stroke code zero.
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_chk(mk_report(KIND_STROKE, '0, '0, '0, '0, 1'b1));
    add_req(OP_SET_THR, 4'd0, '0, 1'b0, 32'd2, 32'd4);
    add_chk(mk_report(KIND_CMD_OK, 4'd0, '0, '0, '0, 1'b1));
    add_req(OP_SET_THR, 4'd1, '0, 1'b0, 32'd5, 32'd3);
    add_chk(mk_report(KIND_BAD_THR, 4'd1, '0, '0, '0, 1'b1));
    add_req(OP_SET_THR, 4'd15, '0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_chk(mk_report(KIND_CMD_OK, 4'd15, '0, '0, '0, 1'b1));
    add_req(OP_SET_THR, 4'd2, '0, 1'b0, 32'd0, 32'd0);
    add_req(OP_SET_THR, 4'd4, '0, 1'b0, 32'd1, 32'd1);
    add_req(OP_SET_EN, 4'd3, '0, 1'b0, '0, '0);
    add_chk(mk_report(KIND_CMD_OK, 4'd3, '0, '0, '0, 1'b1));
    // Entry outside the scan: a zero key matches silently, any other is a wrong key.
    add_req(OP_RETURN, 4'd5, 32'd0, 1'b0, '0, '0);
    add_req(OP_RETURN, 4'd5, 32'hFFFF_FFFF, 1'b0, '0, '0);
    add_chk(mk_report(KIND_WRONG_KEY, 4'd5, 32'hFFFF_FFFF, '0, '0, 1'b1));
    add_reg(CFG_ACTIVE, 32'd16);
    add_reg(CFG_WD_CODE, 32'hA5A5_5A5A);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_req(OP_RETURN, 4'd0, 32'd0, 1'b0, '0, '0);
    add_req(OP_RETURN, 4'd1, 32'h8000_0000, 1'b0, '0, '0);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_req(OP_SET_EN, 4'd3, '0, 1'b1, '0, '0);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    // Saturated scan length with checking off: stroke only.
    add_reg(CFG_ACTIVE, 32'd31);
    add_reg(CFG_HEALTH_EN, 32'd0);
    add_reg(CFG_WD_CODE, 32'hFFFF_FFFF);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_chk(mk_report(KIND_STROKE, '0, '0, '0, 32'hFFFF_FFFF, 1'b1));
    add_req(OP_RETURN, 4'd6, 32'd5, 1'b0, '0, '0);
    add_req(OP_SET_THR, 4'd6, '0, 1'b0, 32'd3, 32'd2);
    add_chk(mk_report(KIND_BAD_THR, 4'd6, '0, '0, '0, 1'b1));
    add_reg(CFG_HEALTH_EN, 32'd1);
    add_reg(CFG_ACTIVE, 32'd1);
    add_reg(CFG_WD_CODE, 32'd0);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);
    add_req(OP_TICK, 4'd0, '0, 1'b0, '0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      quiet = (ph == 2);
      write_reg(CFG_HEALTH_EN, (ph < 2 || $urandom_range(0, 5) != 0) ? 32'd1 : 32'd0);
      case ((ph < 2) ? 2 : $urandom_range(0, 4))
        0:       act = 32'd0;
        1:       act = 32'd1;
        2:       act = 32'd16;
        3:       act = $urandom_range(17, 31);
        default: act = $urandom_range(2, 15);
      endcase
      write_reg(CFG_ACTIVE, act);
      write_reg(CFG_WD_CODE, $urandom());
      for (int n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 39) == 0) settle();
        issue(random_request(), 1'b0, '0);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests, %0d reports over %0d register writes:",
             request_cnt, report_cnt, setting_cnt);
    $display("%0d pings, %0d late warnings, %0d late fatals, %0d wrong keys,",
             kind_seen[KIND_PING], kind_seen[KIND_LATE_WARN], kind_seen[KIND_LATE_FTL],
             kind_seen[KIND_WRONG_KEY]);
    $display("%0d rejected thresholds, %0d strokes.",
             kind_seen[KIND_BAD_THR], kind_seen[KIND_STROKE]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
